>>> rtl/core/twi_pkg.sv
// twi_pkg: shared types and constants for the trie word insert/lookup engine
// no dependencies; used by twi_req_if, twi_walk and the top module

package twi_pkg;

   localparam int NODE_COUNT_DEF    = 1024;
   localparam int ALPHABET_SIZE_DEF = 26;

   localparam int OPCODE_W = 2;
   localparam int LETTER_W = 5;

   // operation codes; the unused fourth code is folded into a whole-word lookup
   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_WHOLE  = 2'd1,
      OP_PREFIX = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL
   } walk_state_type;

endpackage

>>> rtl/core/twi_req_if.sv
// twi_req_if: letter request channel, valid/ready with opcode, letter and last flag
// depends on twi_pkg for field widths

interface twi_req_if;
   logic                          valid;
   logic                          ready;
   logic [twi_pkg::OPCODE_W-1:0]  opcode;
   logic [twi_pkg::LETTER_W-1:0]  letter;
   logic                          last_letter;

   modport source (output valid, output opcode, output letter, output last_letter,
                   input ready);
   modport sink   (input valid, input opcode, input letter, input last_letter,
                   output ready);
endinterface

>>> rtl/core/twi_rsp_if.sv
// twi_rsp_if: word result channel, valid/ready with found flag and status
// no dependencies

interface twi_rsp_if;
   logic valid;
   logic ready;
   logic found;
   logic status;

   modport source (output valid, output found, output status, input ready);
   modport sink   (input valid, input found, input status, output ready);
endinterface

>>> rtl/core/twi_ram.sv
// twi_ram: single-port-write, single-port-read synchronous memory, registered read data
// no dependencies; holds the trie child table

module twi_ram #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/twi_walk.sv
// twi_walk: trie walk controller, clearing sweep, node allocation and result register
// depends on twi_pkg, twi_req_if, twi_rsp_if; drives the child table in twi_ram

module twi_walk #(
   parameter int NODE_COUNT    = twi_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = twi_pkg::ALPHABET_SIZE_DEF,
   localparam int NODE_W  = $clog2(NODE_COUNT),
   localparam int USED_W  = $clog2(NODE_COUNT + 1),
   localparam int DEPTH   = NODE_COUNT * ALPHABET_SIZE,
   localparam int ADDR_W  = $clog2(DEPTH),
   localparam int ENTRY_W = NODE_W + 1
) (
   input  logic               clock,
   input  logic               reset,
   twi_req_if.sink            req,
   twi_rsp_if.source          rsp,
   output logic               mem_wr_en,
   output logic [ADDR_W-1:0]  mem_wr_addr,
   output logic [ENTRY_W-1:0] mem_wr_data,
   output logic               mem_rd_en,
   output logic [ADDR_W-1:0]  mem_rd_addr,
   input  logic [ENTRY_W-1:0] mem_rd_data
);

   // a table entry is {end mark of the child, child index}; index zero means no child

   twi_pkg::walk_state_type state_ff, state_in;
   logic [ADDR_W-1:0]   clear_cnt_ff, clear_cnt_in;
   logic [USED_W-1:0]   nodes_used_ff, nodes_used_in;
   logic [NODE_W-1:0]   cur_node_ff, cur_node_in;
   logic                missed_ff, missed_in;
   twi_pkg::opcode_type held_op_ff, held_op_in;
   logic                inside_ff, inside_in;
   logic                full_ff, full_in;
   logic                step_ff, step_in;
   logic                last_ff, last_in;
   logic [ADDR_W-1:0]   slot_ff, slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff, found_in;
   logic                status_ff, status_in;

   logic                req_acc;
   logic                first;
   twi_pkg::opcode_type req_op;
   twi_pkg::opcode_type eff_op;
   logic [NODE_W-1:0]   eff_node;
   logic                eff_missed;
   logic                in_range;
   logic [ADDR_W-1:0]   rd_addr;

   logic [NODE_W-1:0]   child;
   logic                child_end;
   logic                out_free;
   logic                eval_go;
   logic                ev_missed;
   logic                ev_full;
   logic                ev_end;
   logic [NODE_W-1:0]   ev_node;
   logic [USED_W-1:0]   ev_used;
   logic                ev_wr;
   logic [ENTRY_W-1:0]  ev_data;

   // ---------------- accept side ----------------
   assign req_acc  = req.valid && req.ready;
   assign first    = !inside_ff;
   assign in_range = 32'(req.letter) < ALPHABET_SIZE;

   always_comb begin
      unique case (req.opcode)
         twi_pkg::OP_INSERT: req_op = twi_pkg::OP_INSERT;
         twi_pkg::OP_PREFIX: req_op = twi_pkg::OP_PREFIX;
         default:            req_op = twi_pkg::OP_WHOLE;
      endcase
   end

   assign eff_op     = first ? req_op : held_op_ff;
   assign eff_node   = first ? '0 : cur_node_ff;
   assign eff_missed = first ? 1'b0 : missed_ff;
   assign rd_addr    = ADDR_W'(eff_node) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(req.letter);

   // ---------------- evaluate side ----------------
   assign child     = mem_rd_data[NODE_W-1:0];
   assign child_end = mem_rd_data[NODE_W];
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign eval_go   = !last_ff || out_free;

   always_comb begin
      ev_missed = missed_ff;
      ev_full   = full_ff;
      ev_end    = 1'b0;
      ev_node   = cur_node_ff;
      ev_used   = nodes_used_ff;
      ev_wr     = 1'b0;
      ev_data   = '0;
      if (step_ff) begin
         if (child != '0) begin
            ev_node = child;
            ev_end  = child_end;
            // insert ending on an existing node sets its mark
            if (last_ff && held_op_ff == twi_pkg::OP_INSERT) begin
               ev_wr   = 1'b1;
               ev_data = {1'b1, child};
            end
         end else if (held_op_ff == twi_pkg::OP_INSERT) begin
            if (32'(nodes_used_ff) < NODE_COUNT) begin
               // new rows are already zero from the clearing sweep
               ev_node = nodes_used_ff[NODE_W-1:0];
               ev_used = nodes_used_ff + USED_W'(1);
               ev_wr   = 1'b1;
               ev_data = {last_ff, nodes_used_ff[NODE_W-1:0]};
            end else begin
               ev_missed = 1'b1;
               ev_full   = 1'b1;
            end
         end else begin
            ev_missed = 1'b1;
         end
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         twi_pkg::ST_CLEAR: begin
            if (clear_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = twi_pkg::ST_IDLE;
            end
         end
         twi_pkg::ST_IDLE: begin
            if (req_acc) begin
               state_in = twi_pkg::ST_EVAL;
            end
         end
         twi_pkg::ST_EVAL: begin
            if (eval_go) begin
               state_in = twi_pkg::ST_IDLE;
            end
         end
         default: state_in = twi_pkg::ST_CLEAR;
      endcase
   end

   // ---------------- state outputs ----------------
   always_comb begin
      req.ready   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_addr;
      mem_wr_en   = 1'b0;
      mem_wr_addr = slot_ff;
      mem_wr_data = ev_data;
      unique case (state_ff)
         twi_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clear_cnt_ff;
            mem_wr_data = '0;
         end
         twi_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            // an out-of-range letter misses without a table read
            mem_rd_en = req.valid && in_range;
         end
         twi_pkg::ST_EVAL: begin
            mem_wr_en = ev_wr && eval_go;
         end
         default: ;
      endcase
   end

   // ---------------- register next values ----------------
   always_comb begin
      clear_cnt_in  = clear_cnt_ff;
      nodes_used_in = nodes_used_ff;
      cur_node_in   = cur_node_ff;
      missed_in     = missed_ff;
      held_op_in    = held_op_ff;
      inside_in     = inside_ff;
      full_in       = full_ff;
      step_in       = step_ff;
      last_in       = last_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      found_in      = found_ff;
      status_in     = status_ff;

      if (state_ff == twi_pkg::ST_CLEAR) begin
         clear_cnt_in = clear_cnt_ff + ADDR_W'(1);
      end

      if (req_acc) begin
         held_op_in  = eff_op;
         cur_node_in = eff_node;
         full_in     = first ? 1'b0 : full_ff;
         missed_in   = eff_missed || !in_range;
         step_in     = !eff_missed && in_range;
         last_in     = req.last_letter;
         inside_in   = !req.last_letter;
         slot_in     = rd_addr;
      end

      if (state_ff == twi_pkg::ST_EVAL && eval_go) begin
         cur_node_in   = ev_node;
         nodes_used_in = ev_used;
         missed_in     = ev_missed;
         full_in       = ev_full;
         if (last_ff) begin
            rsp_valid_in = 1'b1;
            unique case (held_op_ff)
               twi_pkg::OP_INSERT: found_in = !ev_missed;
               twi_pkg::OP_PREFIX: found_in = !ev_missed;
               default:            found_in = !ev_missed && ev_end;
            endcase
            status_in = (held_op_ff == twi_pkg::OP_INSERT) && ev_full;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= twi_pkg::ST_CLEAR;
         clear_cnt_ff  <= '0;
         nodes_used_ff <= USED_W'(1);
         cur_node_ff   <= '0;
         missed_ff     <= 1'b0;
         held_op_ff    <= twi_pkg::OP_INSERT;
         inside_ff     <= 1'b0;
         full_ff       <= 1'b0;
         step_ff       <= 1'b0;
         last_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_cnt_ff  <= clear_cnt_in;
         nodes_used_ff <= nodes_used_in;
         cur_node_ff   <= cur_node_in;
         missed_ff     <= missed_in;
         held_op_ff    <= held_op_in;
         inside_ff     <= inside_in;
         full_ff       <= full_in;
         step_ff       <= step_in;
         last_ff       <= last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      found_ff  <= found_in;
      status_ff <= status_in;
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.found  = found_ff;
   assign rsp.status = status_ff;

   // ---------------- assertions ----------------
   a_no_write_on_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == twi_pkg::ST_IDLE) |-> !mem_wr_en)
      else $error("child table written in the read cycle");

   a_pool_bounds: assert property (@(posedge clock) disable iff (reset)
      nodes_used_ff != '0 && 32'(nodes_used_ff) <= NODE_COUNT)
      else $error("node pool count out of range");

   a_node_allocated: assert property (@(posedge clock) disable iff (reset)
      32'(cur_node_ff) < 32'(nodes_used_ff))
      else $error("current node beyond allocated pool");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == twi_pkg::ST_EVAL)
      else $error("accepted transaction not evaluated");

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == twi_pkg::ST_EVAL && last_ff))
      else $error("result raised without a last letter");

endmodule

>>> rtl/core/trie_word_insert_lookup_top.sv
// trie_word_insert_lookup_top: letter-serial trie engine, insert and lookups
// result: rsp_ch.valid is registered when the evaluation state after the last letter's
//   transaction completes; letters: no new letter is taken until the child table read
//   for the last one has returned, as the next letter's address needs it; a result not yet
//   taken holds the next word's last letter in evaluation
// reset: synchronous; a clearing sweep of all NODE_COUNT*ALPHABET_SIZE entries
//   (26624 by default) zeroes the child table while req_ch.ready stays low
// depends on twi_pkg, twi_req_if, twi_rsp_if, twi_ram, twi_walk

module trie_word_insert_lookup_top #(
   parameter int NODE_COUNT    = twi_pkg::NODE_COUNT_DEF,
   parameter int ALPHABET_SIZE = twi_pkg::ALPHABET_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   twi_req_if.sink    req_ch,
   twi_rsp_if.source  rsp_ch
);

   localparam int NODE_W  = $clog2(NODE_COUNT);
   localparam int DEPTH   = NODE_COUNT * ALPHABET_SIZE;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ENTRY_W = NODE_W + 1;

   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [ENTRY_W-1:0] mem_rd_data;

   twi_walk #(
      .NODE_COUNT    (NODE_COUNT),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   twi_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ENTRY_W)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking bench for trie_word_insert_lookup_top, letter-serial words in,
// one found/status transaction per word out, checked against a trie kept in the bench
// depends on twi_pkg, twi_req_if, twi_rsp_if and the rtl/core sources

`timescale 1ns / 100ps

// unused fourth opcode, folded into a whole-word lookup by the block
localparam logic [1:0] OPCODE_SPARE = 2'd3;

typedef struct packed {
   logic found;
   logic status;
} word_result_type;

class trie_scoreboard;
   localparam int NODES  = twi_pkg::NODE_COUNT_DEF;
   localparam int ALPHA  = twi_pkg::ALPHABET_SIZE_DEF;
   localparam int NODE_W = $clog2(NODES);

   bit [NODE_W-1:0]    child_tab [NODES*ALPHA];
   bit                 word_end [NODES];
   bit [NODE_W:0]      nodes_used;
   bit [NODE_W-1:0]    cur_node;
   bit                 missed;
   bit                 in_word;
   bit                 pool_full;
   twi_pkg::opcode_type held_op;

   word_result_type    word_results_q[$];
   int                 errors;
   int                 checked;
   int                 full_count;

   function new();
      foreach (child_tab[i]) child_tab[i] = '0;
      foreach (word_end[i]) word_end[i] = 1'b0;
      nodes_used = 1;
      cur_node   = '0;
      missed     = 1'b0;
      in_word    = 1'b0;
      pool_full  = 1'b0;
      held_op    = twi_pkg::OP_INSERT;
      errors     = 0;
      checked    = 0;
      full_count = 0;
   endfunction

   function int pending();
      return word_results_q.size();
   endfunction

   // walk one letter; a word's result is queued on its last letter
   function void note_letter(logic [1:0] op, logic [4:0] ltr, logic last);
      int           slot;
      bit [NODE_W-1:0] nxt;
      word_result_type res;
      if (!in_word) begin
         held_op   = (op == OPCODE_SPARE) ? twi_pkg::OP_WHOLE : twi_pkg::opcode_type'(op);
         cur_node  = '0;
         missed    = 1'b0;
         pool_full = 1'b0;
         in_word   = 1'b1;
      end
      if (!missed) begin
         if (ltr >= ALPHA) begin
            missed = 1'b1;
         end else begin
            slot = int'(cur_node) * ALPHA + int'(ltr);
            nxt  = child_tab[slot];
            if (nxt != '0) begin
               cur_node = nxt;
            end else if (held_op == twi_pkg::OP_INSERT && nodes_used < NODES) begin
               nxt = nodes_used[NODE_W-1:0];
               for (int i = 0; i < ALPHA; i++) child_tab[int'(nxt) * ALPHA + i] = '0;
               word_end[nxt]   = 1'b0;
               child_tab[slot] = nxt;
               nodes_used++;
               cur_node = nxt;
            end else begin
               missed = 1'b1;
               if (held_op == twi_pkg::OP_INSERT) pool_full = 1'b1;
            end
         end
      end
      if (last) begin
         in_word = 1'b0;
         case (held_op)
            twi_pkg::OP_INSERT: begin
               if (!missed) word_end[cur_node] = 1'b1;
               res.found = !missed;
            end
            twi_pkg::OP_PREFIX: res.found = !missed;
            default:            res.found = !missed && word_end[cur_node];
         endcase
         res.status = (held_op == twi_pkg::OP_INSERT) ? pool_full : 1'b0;
         if (res.status) full_count++;
         word_results_q = {word_results_q, res};
      end
   endfunction

   function void check_result(logic found, logic status);
      word_result_type want;
      checked++;
      if (word_results_q.size() == 0) begin
         $display("%0t: unexpected result transaction found=%b status=%b",
                  $time, found, status);
         errors++;
         return;
      end
      want = word_results_q.pop_front();
      if (found !== want.found) begin
         $display("%0t: found mismatch, expected %b actual %b", $time, want.found, found);
         errors++;
      end
      if (status !== want.status) begin
         $display("%0t: status mismatch, expected %b actual %b", $time, want.status, status);
         errors++;
      end
   endfunction

   function void report_leftover();
      if (word_results_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, word_results_q.size());
         errors += word_results_q.size();
      end
   endfunction
endclass

module tb_top;

   logic clock = 1'b0;
   logic reset = 1'b1;

   twi_req_if req_ch ();
   twi_rsp_if rsp_ch ();

   trie_word_insert_lookup_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   trie_scoreboard board = new();

   int letter_buf[$];
   int dict_letters[$];
   int dict_start[$];
   int dict_len[$];
   int letters_sent = 0;
   int insert_words = 0;
   int lookup_words = 0;
   bit tx_burst = 1'b0;

   task automatic send_letter(input logic [1:0] op, input logic [4:0] ltr, input logic last);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= op;
      req_ch.letter      <= ltr;
      req_ch.last_letter <= last;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      board.note_letter(op, ltr, last);
      letters_sent++;
   endtask

   // opcode on letters after the first is ignored, so it is noise there
   task automatic send_word(input logic [1:0] op);
      tx_burst = ($urandom_range(0, 5) == 0);
      if (op == twi_pkg::OP_INSERT) insert_words++;
      else lookup_words++;
      for (int i = 0; i < letter_buf.size(); i++)
         send_letter((i == 0) ? op : 2'($urandom_range(0, 3)), 5'(letter_buf[i]),
                     i == letter_buf.size() - 1);
   endtask

   task automatic wait_results_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic load_word(input int l0, input int l1 = -1, input int l2 = -1);
      letter_buf = {l0};
      if (l1 >= 0) letter_buf = {letter_buf, l1};
      if (l2 >= 0) letter_buf = {letter_buf, l2};
   endtask

   task automatic random_word(input int len, input int top);
      bit narrow;
      narrow = $urandom_range(0, 1);
      letter_buf = {};
      repeat (len)
         letter_buf = {letter_buf,
                       int'(narrow ? $urandom_range(0, 3) : $urandom_range(0, top))};
   endtask

   // known word, cut short or grown by one letter now and then
   task automatic known_word();
      int k;
      int len;
      int pick;
      k    = $urandom_range(0, dict_start.size() - 1);
      len  = dict_len[k];
      pick = $urandom_range(0, 3);
      if (pick == 1) len = $urandom_range(1, len);
      letter_buf = {};
      for (int i = 0; i < len; i++)
         letter_buf = {letter_buf, dict_letters[dict_start[k] + i]};
      if (pick == 2) letter_buf = {letter_buf, int'($urandom_range(0, 25))};
   endtask

   task automatic remember_word();
      dict_start = {dict_start, dict_letters.size()};
      dict_len   = {dict_len, letter_buf.size()};
      foreach (letter_buf[i]) dict_letters = {dict_letters, letter_buf[i]};
   endtask

   // result side: random stalls, one long hold-off to back the block up
   initial begin : result_sink
      int stall;
      int rx_count;
      bit rx_burst;
      rx_count = 0;
      rx_burst = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
         stall = rx_burst ? 0 : $urandom_range(0, 12);
         if (rx_count == 40) stall = 400;
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (rsp_ch.valid !== 1'b1) @(posedge clock);
         board.check_result(rsp_ch.found, rsp_ch.status);
         rx_count++;
      end
   end

   initial begin : stimulus
      int r;
      req_ch.valid       <= 1'b0;
      req_ch.opcode      <= twi_pkg::OP_INSERT;
      req_ch.letter      <= '0;
      req_ch.last_letter <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed words: both letter extremes, all opcodes, misses, out-of-range letters
      load_word(0);          send_word(twi_pkg::OP_INSERT);
      load_word(25);         send_word(twi_pkg::OP_INSERT);
      load_word(0, 1);       send_word(twi_pkg::OP_INSERT);
      load_word(0);          send_word(twi_pkg::OP_WHOLE);
      load_word(0, 1);       send_word(twi_pkg::OP_WHOLE);
      load_word(0, 1, 2);    send_word(twi_pkg::OP_WHOLE);
      load_word(0);          send_word(twi_pkg::OP_PREFIX);
      load_word(25, 25);     send_word(twi_pkg::OP_WHOLE);
      load_word(1);          send_word(twi_pkg::OP_PREFIX);
      load_word(25);         send_word(OPCODE_SPARE);
      load_word(31);         send_word(twi_pkg::OP_INSERT);
      load_word(16, 26, 3);  send_word(twi_pkg::OP_INSERT);
      load_word(16);         send_word(twi_pkg::OP_PREFIX);
      load_word(16);         send_word(twi_pkg::OP_WHOLE);
      load_word(30);         send_word(twi_pkg::OP_WHOLE);
      wait_results_drained();

      // random words, mostly well formed with shared prefixes
      while (letters_sent < 420) begin
         r = $urandom_range(0, 99);
         if (r < 35 || dict_start.size() == 0) begin
            random_word($urandom_range(1, 6), 25);
            remember_word();
            send_word(twi_pkg::OP_INSERT);
         end else if (r < 60) begin
            known_word();
            send_word(($urandom_range(0, 4) == 0) ? OPCODE_SPARE : twi_pkg::OP_WHOLE);
         end else if (r < 80) begin
            known_word();
            send_word(twi_pkg::OP_PREFIX);
         end else begin
            random_word($urandom_range(1, 4), 31);
            send_word(2'($urandom_range(0, 3)));
         end
      end
      wait_results_drained();

      // long distinct inserts until the node pool runs dry, then use it full
      while (board.nodes_used < twi_pkg::NODE_COUNT_DEF) begin
         random_word(20, 25);
         send_word(twi_pkg::OP_INSERT);
      end
      repeat (4) begin
         random_word(5, 25);
         send_word(twi_pkg::OP_INSERT);
      end
      repeat (6) begin
         known_word();
         send_word(2'($urandom_range(0, 3)));
      end
      load_word(28);         send_word(twi_pkg::OP_INSERT);
      wait_results_drained();
      repeat (8) @(posedge clock);

      board.report_leftover();
      $display("tb: %0d letters in %0d inserts and %0d lookups, %0d results checked",
               letters_sent, insert_words, lookup_words, board.checked);
      $display("tb: %0d inserts hit an exhausted pool, %0d nodes in use, %0d errors",
               board.full_count, board.nodes_used, board.errors);
      if (board.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
